[rtl/slcs_pkg.sv]
package slcs_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_LIGHT_POSITION   = 3'd0,
		REG_SPOT_AXIS        = 3'd1,
		REG_INTENSITY        = 3'd2,
		REG_COS_INNER        = 3'd3,
		REG_COS_OUTER        = 3'd4,
		REG_CONE_SCALE       = 3'd5,
		REG_FALLOFF_EXPONENT = 3'd6,
		REG_DARK_THRESHOLD   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_DARK,
		MODE_FULL,
		MODE_ZERO,
		MODE_POW
	} mode_t;

	typedef struct packed {
		logic [2:0][15:0] light;
		logic [2:0][15:0] axis;
		logic [3:0][15:0] intensity;
		logic [15:0]      cos_inner;
		logic [15:0]      cos_outer;
		logic [23:0]      cone_scale;
		logic [15:0]      falloff;
		logic [15:0]      dark;
	} cfg_t;

	typedef struct packed {
		logic [2:0][15:0] dir;
		logic [16:0]      base;
		mode_t            mode;
	} cone_t;

	typedef struct packed {
		logic [3:0][15:0] ch;
		logic [2:0][15:0] dir;
		logic             lit;
	} res_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] x;
		logic [63:0] bit_w;
		res   = '0;
		x     = v;
		bit_w = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + bit_w) begin
				x   = x - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// 2^30 * 2^(-2^-k)
	function automatic logic [29:0] exp_coef(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int j = 2; j <= k; j++) begin
			c = isqrt64(c << 30);
		end
		return c[29:0];
	endfunction

endpackage

[rtl/slcs_front.sv]
module slcs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  slcs_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         pos_x,
	input  logic [15:0]         pos_y,
	input  logic [15:0]         pos_z,
	output logic                out_valid,
	input  logic                out_ready,
	output slcs_pkg::cone_t     out_item
);

	localparam int SQ0 = 3;
	localparam int SQN = 17;
	localparam int DV0 = SQ0 + SQN + 1;
	localparam int DVN = 15;
	localparam int DIR = DV0 + DVN;
	localparam int PRD = DIR + 1;
	localparam int CLS = PRD + 1;
	localparam int BMU = CLS + 1;
	localparam int FIN = BMU + 1;
	localparam int NF  = FIN + 1;

	typedef struct packed {
		logic [2:0][16:0] d;
		logic [2:0][31:0] sq;
		logic [33:0]      rem;
		logic [16:0]      root;
		logic             zero;
		logic [2:0][29:0] drem;
		logic [2:0][14:0] q;
		logic [2:0][15:0] dir;
		logic [2:0][31:0] prod;
		slcs_pkg::mode_t  mode;
		logic [17:0]      diff;
		logic [41:0]      bprod;
		logic [16:0]      base;
	} front_t;

	front_t stage_q [NF];
	front_t nxt     [NF];
	logic   v_q     [NF];
	logic   en;

	assign en        = !v_q[NF-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q[NF-1];
	assign out_item.dir  = stage_q[NF-1].dir;
	assign out_item.base = stage_q[NF-1].base;
	assign out_item.mode = stage_q[NF-1].mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NF; i++) v_q[i] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < NF; i++) v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NF; i++) stage_q[i] <= nxt[i];
		end
	end

	for (genvar i = 0; i < NF; i++) begin : g_stage
		if (i == 0) begin : g_delta
			always_comb begin
				nxt[i] = '0;
				nxt[i].d[0] = {cfg.light[0][15], cfg.light[0]} - {pos_x[15], pos_x};
				nxt[i].d[1] = {cfg.light[1][15], cfg.light[1]} - {pos_y[15], pos_y};
				nxt[i].d[2] = {cfg.light[2][15], cfg.light[2]} - {pos_z[15], pos_z};
			end
		end else if (i == 1) begin : g_square
			always_comb begin
				logic signed [33:0] p;
				nxt[i] = stage_q[i-1];
				for (int l = 0; l < 3; l++) begin
					p = $signed(stage_q[i-1].d[l]) * $signed(stage_q[i-1].d[l]);
					nxt[i].sq[l] = p[31:0];
				end
			end
		end else if (i == 2) begin : g_sum
			always_comb begin
				logic [33:0] rr;
				nxt[i] = stage_q[i-1];
				rr = {2'b0, stage_q[i-1].sq[0]} + {2'b0, stage_q[i-1].sq[1]}
					+ {2'b0, stage_q[i-1].sq[2]};
				nxt[i].rem  = rr;
				nxt[i].root = '0;
				nxt[i].zero = (rr == '0);
			end
		end else if (i >= SQ0 && i < SQ0 + SQN) begin : g_sqrt
			localparam int B = SQN - 1 - (i - SQ0);
			always_comb begin
				logic [34:0] tr;
				nxt[i] = stage_q[i-1];
				tr = (35'(stage_q[i-1].root) << (B + 1)) + (35'(1) << (2 * B));
				if ({1'b0, stage_q[i-1].rem} >= tr) begin
					nxt[i].rem     = stage_q[i-1].rem - tr[33:0];
					nxt[i].root[B] = 1'b1;
				end
			end
		end else if (i == DV0 - 1) begin : g_div_init
			always_comb begin
				logic [16:0] mag;
				nxt[i] = stage_q[i-1];
				for (int l = 0; l < 3; l++) begin
					mag = stage_q[i-1].d[l][16] ? 17'd0 - stage_q[i-1].d[l]
						: stage_q[i-1].d[l];
					nxt[i].drem[l] = {mag[15:0], 14'b0};
					nxt[i].q[l]    = '0;
				end
			end
		end else if (i >= DV0 && i < DV0 + DVN) begin : g_div
			localparam int B = DVN - 1 - (i - DV0);
			always_comb begin
				logic [31:0] tr;
				nxt[i] = stage_q[i-1];
				tr = 32'(stage_q[i-1].root) << B;
				for (int l = 0; l < 3; l++) begin
					if ({2'b0, stage_q[i-1].drem[l]} >= tr) begin
						nxt[i].drem[l] = stage_q[i-1].drem[l] - tr[29:0];
						nxt[i].q[l][B] = 1'b1;
					end
				end
			end
		end else if (i == DIR) begin : g_dir
			always_comb begin
				logic [15:0] qq;
				nxt[i] = stage_q[i-1];
				for (int l = 0; l < 3; l++) begin
					qq = {1'b0, stage_q[i-1].q[l]};
					nxt[i].dir[l] = stage_q[i-1].d[l][16] ? 16'd0 - qq : qq;
				end
			end
		end else if (i == PRD) begin : g_prod
			always_comb begin
				logic signed [31:0] pp;
				nxt[i] = stage_q[i-1];
				for (int l = 0; l < 3; l++) begin
					pp = $signed(cfg.axis[l]) * $signed(stage_q[i-1].dir[l]);
					nxt[i].prod[l] = pp;
				end
			end
		end else if (i == CLS) begin : g_class
			always_comb begin
				logic signed [33:0] sum;
				logic signed [17:0] dot_w;
				logic signed [17:0] ci_w;
				logic signed [17:0] co_w;
				logic signed [18:0] diff_w;
				nxt[i] = stage_q[i-1];
				sum = $signed({{2{stage_q[i-1].prod[0][31]}}, stage_q[i-1].prod[0]})
					+ $signed({{2{stage_q[i-1].prod[1][31]}}, stage_q[i-1].prod[1]})
					+ $signed({{2{stage_q[i-1].prod[2][31]}}, stage_q[i-1].prod[2]});
				dot_w  = 18'(sum >>> 14);
				ci_w   = $signed({{2{cfg.cos_inner[15]}}, cfg.cos_inner});
				co_w   = $signed({{2{cfg.cos_outer[15]}}, cfg.cos_outer});
				diff_w = $signed({dot_w[17], dot_w}) - $signed({co_w[17], co_w});
				nxt[i].diff = diff_w[17:0];
				if (stage_q[i-1].zero) nxt[i].mode = slcs_pkg::MODE_DARK;
				else if (dot_w >= ci_w) nxt[i].mode = slcs_pkg::MODE_FULL;
				else if (dot_w <= co_w) nxt[i].mode = slcs_pkg::MODE_DARK;
				else nxt[i].mode = slcs_pkg::MODE_POW;
			end
		end else if (i == BMU) begin : g_bmul
			always_comb begin
				nxt[i] = stage_q[i-1];
				nxt[i].bprod = stage_q[i-1].diff * cfg.cone_scale;
			end
		end else begin : g_final
			always_comb begin
				logic [31:0] b32;
				nxt[i] = stage_q[i-1];
				b32 = stage_q[i-1].bprod[41:10];
				nxt[i].base = (b32 > 32'd65536) ? 17'd65536 : b32[16:0];
				if (stage_q[i-1].mode == slcs_pkg::MODE_POW) begin
					if (cfg.falloff == '0) nxt[i].mode = slcs_pkg::MODE_FULL;
					else if (nxt[i].base == '0) nxt[i].mode = slcs_pkg::MODE_ZERO;
				end
			end
		end
	end

endmodule

[rtl/slcs_queue.sv]
module slcs_queue #(
	parameter int DEPTH = slcs_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            in_ready,
	input  slcs_pkg::cone_t push_item,
	input  logic            pop,
	output logic            out_valid,
	output slcs_pkg::cone_t head_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	slcs_pkg::cone_t mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign head_item = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_item;
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wptr_q == rptr_q))
		else $error("queue pointers differ while empty");

endmodule

[rtl/slcs_back.sv]
module slcs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  slcs_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            pop,
	input  slcs_pkg::cone_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output slcs_pkg::res_t  out_item
);

	localparam int LG0 = 2;
	localparam int LGN = 16;
	localparam int TMU = LG0 + LGN;
	localparam int EX0 = TMU + 1;
	localparam int EXN = 16;
	localparam int SHF = EX0 + EXN;
	localparam int CHM = SHF + 1;
	localparam int OUT = CHM + 1;
	localparam int NB  = OUT + 1;

	typedef struct packed {
		logic [2:0][15:0] dir;
		slcs_pkg::mode_t  mode;
		logic [16:0]      base;
		logic [4:0]       pz;
		logic [17:0]      m;
		logic [15:0]      frac;
		logic [24:0]      t;
		logic [30:0]      acc;
		logic [16:0]      s;
		logic [3:0][15:0] ch;
		logic             lit;
	} back_t;

	back_t stage_q [NB];
	back_t nxt     [NB];
	logic  v_q     [NB];
	logic  en;

	assign en        = !v_q[NB-1] || out_ready;
	assign pop       = en && in_valid;
	assign out_valid = v_q[NB-1];
	assign out_item.dir = stage_q[NB-1].dir;
	assign out_item.ch  = stage_q[NB-1].ch;
	assign out_item.lit = stage_q[NB-1].lit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NB; i++) v_q[i] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < NB; i++) v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NB; i++) stage_q[i] <= nxt[i];
		end
	end

	for (genvar i = 0; i < NB; i++) begin : g_stage
		if (i == 0) begin : g_load
			always_comb begin
				nxt[i] = '0;
				nxt[i].dir  = in_item.dir;
				nxt[i].base = in_item.base;
				nxt[i].mode = in_item.mode;
			end
		end else if (i == 1) begin : g_norm
			always_comb begin
				logic [4:0] p;
				nxt[i] = stage_q[i-1];
				p = '0;
				for (int j = 0; j < 17; j++) begin
					if (stage_q[i-1].base[j]) p = 5'(j);
				end
				nxt[i].pz   = 5'd16 - p;
				nxt[i].m    = 18'(stage_q[i-1].base) << nxt[i].pz;
				nxt[i].frac = '0;
			end
		end else if (i >= LG0 && i < LG0 + LGN) begin : g_log
			always_comb begin
				logic [33:0] sqw;
				logic [17:0] ms;
				nxt[i] = stage_q[i-1];
				sqw = stage_q[i-1].m[16:0] * stage_q[i-1].m[16:0];
				ms  = sqw[33:16];
				if (ms[17]) begin
					nxt[i].frac = {stage_q[i-1].frac[14:0], 1'b1};
					nxt[i].m    = {1'b0, ms[17:1]};
				end else begin
					nxt[i].frac = {stage_q[i-1].frac[14:0], 1'b0};
					nxt[i].m    = ms;
				end
			end
		end else if (i == TMU) begin : g_tmul
			always_comb begin
				logic [20:0] n;
				logic [36:0] tw;
				nxt[i] = stage_q[i-1];
				n  = {stage_q[i-1].pz, 16'b0} - {5'b0, stage_q[i-1].frac};
				tw = n * cfg.falloff;
				nxt[i].t   = tw[36:12];
				nxt[i].acc = 31'h4000_0000;
			end
		end else if (i >= EX0 && i < EX0 + EXN) begin : g_exp
			localparam int K = i - EX0 + 1;
			localparam logic [29:0] C = slcs_pkg::exp_coef(K);
			always_comb begin
				logic [60:0] pw;
				nxt[i] = stage_q[i-1];
				pw = stage_q[i-1].acc * C;
				if (stage_q[i-1].t[16-K]) nxt[i].acc = pw[60:30];
			end
		end else if (i == SHF) begin : g_shift
			always_comb begin
				logic [8:0] ip;
				nxt[i] = stage_q[i-1];
				ip = stage_q[i-1].t[24:16];
				case (stage_q[i-1].mode)
					slcs_pkg::MODE_FULL: nxt[i].s = 17'd65536;
					slcs_pkg::MODE_POW:
						nxt[i].s = (ip > 9'd20) ? 17'd0 : stage_q[i-1].acc[30:14] >> ip[4:0];
					default: nxt[i].s = '0;
				endcase
			end
		end else if (i == CHM) begin : g_chan
			always_comb begin
				logic [32:0] cw;
				nxt[i] = stage_q[i-1];
				for (int l = 0; l < 4; l++) begin
					cw = cfg.intensity[l] * stage_q[i-1].s;
					nxt[i].ch[l] = cw[31:16];
				end
			end
		end else begin : g_out
			always_comb begin
				logic dark;
				nxt[i] = stage_q[i-1];
				dark = (stage_q[i-1].ch[0] < cfg.dark) && (stage_q[i-1].ch[1] < cfg.dark)
					&& (stage_q[i-1].ch[2] < cfg.dark);
				nxt[i].lit = (stage_q[i-1].mode != slcs_pkg::MODE_DARK) && !dark;
				if (!nxt[i].lit) begin
					nxt[i].dir = '0;
					nxt[i].ch  = '0;
				end
			end
		end
	end

endmodule

[rtl/spot_light_cone_sample_unit.sv]
// spot light cone sample unit
// s_* carries one surface position per beat, m_* one result sample per beat.
// cfg_we/cfg_index/cfg_data write the light registers; write only while idle.
// a front pipeline (sqrt, three dividers, dot, cone classify) feeds a short
// queue; a back pipeline (log2 squaring chain, exp2 multiply chain, colour
// scale, dark test) drains it into the output register.
// throughput: one beat per cycle unless the output stalls, set by one stage per
// sqrt, divide, log2 and exp2 step.
// m_tuser is 1 for a lit sample; an unlit sample has all data zero.
// reset clears all valid flags and the queue and loads register defaults.
// when m_tready is low the back pipeline holds, the queue fills, and then the
// front pipeline holds and s_tready drops; no beat is lost.
module spot_light_cone_sample_unit #(
	parameter int QUEUE_DEPTH = slcs_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // pos_x, pos_y, pos_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // dir_x, dir_y, dir_z, red, green, blue, alpha
	output logic         m_tuser,   // lit
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	slcs_pkg::cfg_t  cfg_q;
	slcs_pkg::cone_t f_item;
	slcs_pkg::cone_t q_item;
	slcs_pkg::res_t  res;
	logic            f_valid;
	logic            q_ready;
	logic            q_valid;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light      <= '0;
			cfg_q.axis       <= '0;
			cfg_q.intensity  <= '0;
			cfg_q.cos_inner  <= 16'd16384;
			cfg_q.cos_outer  <= '0;
			cfg_q.cone_scale <= 24'd4096;
			cfg_q.falloff    <= 16'd4096;
			cfg_q.dark       <= 16'd1;
		end else if (cfg_we) begin
			case (slcs_pkg::reg_idx_t'(cfg_index))
				slcs_pkg::REG_LIGHT_POSITION:   cfg_q.light      <= cfg_data[47:0];
				slcs_pkg::REG_SPOT_AXIS:        cfg_q.axis       <= cfg_data[47:0];
				slcs_pkg::REG_INTENSITY:        cfg_q.intensity  <= cfg_data;
				slcs_pkg::REG_COS_INNER:        cfg_q.cos_inner  <= cfg_data[15:0];
				slcs_pkg::REG_COS_OUTER:        cfg_q.cos_outer  <= cfg_data[15:0];
				slcs_pkg::REG_CONE_SCALE:       cfg_q.cone_scale <= cfg_data[23:0];
				slcs_pkg::REG_FALLOFF_EXPONENT: cfg_q.falloff    <= cfg_data[15:0];
				slcs_pkg::REG_DARK_THRESHOLD:   cfg_q.dark       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	slcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pos_x     (s_tdata[15:0]),
		.pos_y     (s_tdata[31:16]),
		.pos_z     (s_tdata[47:32]),
		.out_valid (f_valid),
		.out_ready (q_ready),
		.out_item  (f_item)
	);

	slcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid && q_ready),
		.in_ready  (q_ready),
		.push_item (f_item),
		.pop       (pop),
		.out_valid (q_valid),
		.head_item (q_item)
	);

	slcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (q_valid),
		.pop       (pop),
		.in_item   (q_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (res)
	);

	assign m_tdata = {res.ch, res.dir};
	assign m_tuser = res.lit;

endmodule
